@@ rtl/core/smpq_pkg.sv @@
// Shared types and constants for the stable max priority queue core.
package smpq_pkg;

    // Fixed field widths of the item channels
    localparam int POS_W = 5;
    localparam int CNT_W = 5;

    // Operation codes carried by a request item
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_INSERT,
        DP_CLEAR,
        DP_FAIL,
        DP_READ_START,
        DP_READ_DONE,
        DP_SCAN_START,
        DP_SCAN,
        DP_SHIFT
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   load_out;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_ok;
        logic idx_last;
        logic tail;
    } status_t;

endpackage

@@ rtl/core/smpq_req_if.sv @@
// Request channel: command item with valid/ready handshake.
interface smpq_req_if #(
    parameter int SEV_W = 8,
    parameter int REC_W = 32
);
    logic                       valid;
    logic                       ready;
    smpq_pkg::cmd_t             command;
    logic [SEV_W-1:0]           severity;
    logic [REC_W-1:0]           record;
    logic [smpq_pkg::POS_W-1:0] position;

    modport source (output valid, command, severity, record, position, input ready);
    modport sink   (input valid, command, severity, record, position, output ready);
endinterface

@@ rtl/core/smpq_rsp_if.sv @@
// Result channel: one result item per request, valid/ready handshake.
interface smpq_rsp_if #(
    parameter int SEV_W = 8,
    parameter int REC_W = 32
);
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [SEV_W-1:0]           out_severity;
    logic [REC_W-1:0]           out_record;
    logic [smpq_pkg::CNT_W-1:0] count;

    modport source (output valid, ok, out_severity, out_record, count, input ready);
    modport sink   (input valid, ok, out_severity, out_record, count, output ready);
endinterface

@@ rtl/core/smpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module smpq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ rtl/core/smpq_datapath.sv @@
// Datapath: entry RAM, fill count, scan/shift index, best tracker, result regs.
module smpq_datapath #(
    parameter int DEPTH         = 16,
    parameter int SEVERITY_BITS = 8,
    parameter int RECORD_BITS   = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  smpq_pkg::ctrl_t            ctrl,
    input  logic [SEVERITY_BITS-1:0]   req_severity,
    input  logic [RECORD_BITS-1:0]     req_record,
    input  logic [smpq_pkg::POS_W-1:0] req_position,
    output smpq_pkg::status_t          status,
    output logic                       out_ok,
    output logic [SEVERITY_BITS-1:0]   out_severity,
    output logic [RECORD_BITS-1:0]     out_record,
    output logic [smpq_pkg::CNT_W-1:0] out_count
);
    import smpq_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int XW0 = (CW > POS_W) ? CW : POS_W;
    localparam int XW  = (XW0 > CNT_W) ? XW0 : CNT_W;
    localparam int EW  = SEVERITY_BITS + RECORD_BITS;

    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [AW-1:0]            best_idx_reg, best_idx_next;
    logic [SEVERITY_BITS-1:0] best_sev_reg, best_sev_next;
    logic [RECORD_BITS-1:0]   best_rec_reg, best_rec_next;
    logic                     res_ok_reg, res_ok_next;
    logic [SEVERITY_BITS-1:0] res_sev_reg, res_sev_next;
    logic [RECORD_BITS-1:0]   res_rec_reg, res_rec_next;
    logic                     out_ok_reg;
    logic [SEVERITY_BITS-1:0] out_sev_reg;
    logic [RECORD_BITS-1:0]   out_rec_reg;
    logic [CNT_W-1:0]         out_count_reg;

    logic                     wr_en, rd_en;
    logic [AW-1:0]            wr_addr, rd_addr;
    logic [EW-1:0]            wr_data, rd_data;
    logic [SEVERITY_BITS-1:0] rd_sev;
    logic [RECORD_BITS-1:0]   rd_rec;
    logic [XW-1:0]            pos_x, pos_m1, count_x;
    logic                     take;

    smpq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_sev  = rd_data[EW-1:RECORD_BITS];
    assign rd_rec  = rd_data[RECORD_BITS-1:0];
    assign pos_x   = XW'(req_position);
    assign pos_m1  = pos_x - XW'(1);
    assign count_x = XW'(count_reg);

    // Strictly greater keeps the oldest among equal severities
    assign take = (idx_reg == '0) || (rd_sev > best_sev_reg);

    always_comb
    begin
        best_idx_next = take ? idx_reg : best_idx_reg;
        best_sev_next = take ? rd_sev : best_sev_reg;
        best_rec_next = take ? rd_rec : best_rec_reg;
    end

    // Status for the controller
    always_comb
    begin
        status.full     = (count_reg == CW'(DEPTH));
        status.empty    = (count_reg == '0);
        status.pos_ok   = (pos_x != '0) && (pos_x <= count_x);
        status.idx_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
        status.tail     = ((CW'(best_idx_next) + CW'(1)) < count_reg);
    end

    // Operation decode
    always_comb
    begin
        wr_en        = 1'b0;
        wr_addr      = idx_reg - AW'(1);
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = '0;
        count_next   = count_reg;
        idx_next     = idx_reg;
        res_ok_next  = res_ok_reg;
        res_sev_next = res_sev_reg;
        res_rec_next = res_rec_reg;
        case (ctrl.op)
            DP_INSERT:
            begin
                res_ok_next  = !status.full;
                res_sev_next = '0;
                res_rec_next = '0;
                if (!status.full)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[AW-1:0];
                    wr_data    = {req_severity, req_record};
                    count_next = count_reg + CW'(1);
                end
            end
            DP_CLEAR:
            begin
                res_ok_next  = !status.empty;
                res_sev_next = '0;
                res_rec_next = '0;
                count_next   = '0;
            end
            DP_FAIL:
            begin
                res_ok_next  = 1'b0;
                res_sev_next = '0;
                res_rec_next = '0;
            end
            DP_READ_START:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_m1[AW-1:0];
            end
            DP_READ_DONE:
            begin
                res_ok_next  = 1'b1;
                res_sev_next = rd_sev;
                res_rec_next = rd_rec;
            end
            DP_SCAN_START:
            begin
                rd_en    = 1'b1;
                rd_addr  = '0;
                idx_next = '0;
            end
            DP_SCAN:
            begin
                if (!status.idx_last)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    res_ok_next  = 1'b1;
                    res_sev_next = best_sev_next;
                    res_rec_next = best_rec_next;
                    if (status.tail)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = best_idx_next + AW'(1);
                        idx_next = best_idx_next + AW'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            DP_SHIFT:
            begin
                // Move entry idx down into idx-1
                wr_en = 1'b1;
                if (!status.idx_last)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        res_ok_reg  <= res_ok_next;
        res_sev_reg <= res_sev_next;
        res_rec_reg <= res_rec_next;
        if (ctrl.op == DP_SCAN)
        begin
            best_idx_reg <= best_idx_next;
            best_sev_reg <= best_sev_next;
            best_rec_reg <= best_rec_next;
        end
        if (ctrl.load_out)
        begin
            out_ok_reg    <= res_ok_reg;
            out_sev_reg   <= res_sev_reg;
            out_rec_reg   <= res_rec_reg;
            out_count_reg <= count_x[CNT_W-1:0];
        end
    end

    assign out_ok       = out_ok_reg;
    assign out_severity = out_sev_reg;
    assign out_record   = out_rec_reg;
    assign out_count    = out_count_reg;
endmodule

@@ rtl/core/smpq_controller.sv @@
// Controller: sequences accept, read wait, scan, shift and result hand-off.
module smpq_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  smpq_pkg::cmd_t    req_command,
    output logic              req_ready,
    input  logic              out_ready,
    output logic              out_valid,
    input  smpq_pkg::status_t status,
    output smpq_pkg::ctrl_t   ctrl
);
    import smpq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and datapath command
    always_comb
    begin
        state_next     = state_reg;
        ctrl.op        = DP_NOP;
        ctrl.load_out  = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_FINISH;
                    case (req_command)
                        CMD_INSERT: ctrl.op = DP_INSERT;
                        CMD_CLEAR:  ctrl.op = DP_CLEAR;
                        CMD_READ:
                        begin
                            if (status.pos_ok)
                            begin
                                ctrl.op    = DP_READ_START;
                                state_next = ST_READ_WAIT;
                            end
                            else
                            begin
                                ctrl.op = DP_FAIL;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (status.empty)
                            begin
                                ctrl.op = DP_FAIL;
                            end
                            else
                            begin
                                ctrl.op    = DP_SCAN_START;
                                state_next = ST_SCAN;
                            end
                        end
                        default: ctrl.op = DP_FAIL;
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                ctrl.op    = DP_READ_DONE;
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                ctrl.op = DP_SCAN;
                if (status.idx_last)
                begin
                    state_next = status.tail ? ST_SHIFT : ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                ctrl.op = DP_SHIFT;
                if (status.idx_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    ctrl.load_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

@@ rtl/core/stable_max_priority_queue_core.sv @@
// Top level of the stable max priority queue core.
// Holds up to DEPTH entries (severity plus record word) in arrival order in one
// RAM with a registered read port. One request item gives one result item.
// A request is taken only while the controller is idle; the result then sits in
// an output register and the next request may be taken while it waits.
// From accept to result loaded: insert, clear and any failed command need no
// RAM read; read-at-position takes one RAM read. Remove-max first scans all
// stored entries for the oldest maximum with one RAM read per cycle, then moves
// the younger entries down by one with one read and one write per cycle.
module stable_max_priority_queue_core #(
    parameter int DEPTH         = 16,
    parameter int SEVERITY_BITS = 8,
    parameter int RECORD_BITS   = 32
) (
    input logic        clk,
    input logic        rst_n,
    smpq_req_if.sink   req,
    smpq_rsp_if.source rsp
);
    import smpq_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    smpq_controller u_controller (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .status      (status),
        .ctrl        (ctrl)
    );

    smpq_datapath #(
        .DEPTH         (DEPTH),
        .SEVERITY_BITS (SEVERITY_BITS),
        .RECORD_BITS   (RECORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .req_severity (req.severity),
        .req_record   (req.record),
        .req_position (req.position),
        .status       (status),
        .out_ok       (rsp.ok),
        .out_severity (rsp.out_severity),
        .out_record   (rsp.out_record),
        .out_count    (rsp.count)
    );
endmodule

@@ rtl/core/smpq_checker.sv @@
// Port-level checker for the queue core and its bind to the top level.
module smpq_checker #(
    parameter int DEPTH         = 16,
    parameter int SEVERITY_BITS = 8,
    parameter int RECORD_BITS   = 32
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       rsp_ok,
    input logic [SEVERITY_BITS-1:0]   rsp_severity,
    input logic [RECORD_BITS-1:0]     rsp_record,
    input logic [smpq_pkg::CNT_W-1:0] rsp_count
);
    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_severity)
            && $stable(rsp_record) && $stable(rsp_count))
    else $error("result item changed while stalled");

    // Only one request is in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in work");

    // Failed commands never return entry data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_severity == '0 && rsp_record == '0)
    else $error("failed result carries entry data");

    // The reported count never exceeds the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (DEPTH > 31) || (int'(rsp_count) <= DEPTH))
    else $error("count beyond capacity");
endmodule

bind stable_max_priority_queue_core smpq_checker #(
    .DEPTH         (DEPTH),
    .SEVERITY_BITS (SEVERITY_BITS),
    .RECORD_BITS   (RECORD_BITS)
) u_smpq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_ok       (rsp.ok),
    .rsp_severity (rsp.out_severity),
    .rsp_record   (rsp.out_record),
    .rsp_count    (rsp.count)
);
